FILE: src/sfpr_pkg.sv
// Shared types and constants for the scaled fixed-point ratio core.
`default_nettype none

package sfpr_pkg;

   localparam int DATA_W_DEF = 64;
   localparam int FIELD_W    = 64;
   localparam int SCALE_W    = 20;
   localparam int STATUS_W   = 2;

   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(100000);

   localparam logic [STATUS_W-1:0] STATUS_OK  = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_NEG = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_OVF = STATUS_W'(2);

   typedef enum logic [1:0] {
      KIND_DIV,
      KIND_PASS,
      KIND_NEG,
      KIND_OVF
   } kind_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
   } sfpr_ctl_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] numerator_total;
      logic signed [FIELD_W-1:0] denominator_total;
   } sfpr_req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] ratio;
      logic [STATUS_W-1:0]       status;
   } sfpr_rsp_type;

endpackage

`default_nettype wire

FILE: src/sfpr_front.sv
// Front stages: request classification, scaled product and overflow check.
`default_nettype none

module sfpr_front
   import sfpr_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_W_DEF,
   localparam int MagW = DATA_WIDTH - 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  enable,
   input  wire logic [SCALE_W-1:0]    scale,
   input  wire logic                  up_valid,
   input  wire sfpr_req_type          up_data,
   output sfpr_ctl_type               dn_ctl,
   output logic [MagW-1:0]            dn_rem,
   output logic [MagW-1:0]            dn_work,
   output logic [DATA_WIDTH-1:0]      dn_aux
);

   localparam int LoW   = (MagW + 1) / 2;
   localparam int HiW   = MagW - LoW;
   localparam int LoPW  = LoW + SCALE_W;
   localparam int HiPW  = HiW + SCALE_W;
   localparam int ProdW = MagW + SCALE_W;
   localparam int CmpW  = (SCALE_W > DATA_WIDTH) ? SCALE_W : DATA_WIDTH;

   logic [DATA_WIDTH-1:0] num;
   logic [DATA_WIDTH-1:0] den;

   sfpr_ctl_type          a_ctl_ff, a_ctl_in;
   logic [DATA_WIDTH-1:0] a_aux_ff, a_aux_in;
   logic [LoPW-1:0]       a_plo_ff, a_plo_in;
   logic [HiPW-1:0]       a_phi_ff, a_phi_in;

   sfpr_ctl_type          b_ctl_ff;
   logic [DATA_WIDTH-1:0] b_aux_ff;
   logic [ProdW-1:0]      b_prod_ff, b_prod_in;

   sfpr_ctl_type          c_ctl_ff, c_ctl_in;
   logic [DATA_WIDTH-1:0] c_aux_ff;
   logic [MagW-1:0]       c_rem_ff, c_rem_in;
   logic [MagW-1:0]       c_work_ff, c_work_in;

   logic [CmpW-1:0]       hi_ext;
   logic [CmpW-1:0]       den_ext;
   logic                  ovf;

   always_comb begin
      num = up_data.numerator_total[DATA_WIDTH-1:0];
      den = up_data.denominator_total[DATA_WIDTH-1:0];
      a_ctl_in.valid = up_valid;
      if (den == '0 || den[DATA_WIDTH-1]) begin
         a_ctl_in.kind = KIND_PASS;
         a_aux_in      = num;
      end else if (num[DATA_WIDTH-1]) begin
         a_ctl_in.kind = KIND_NEG;
         a_aux_in      = den;
      end else begin
         a_ctl_in.kind = KIND_DIV;
         a_aux_in      = den;
      end
      a_plo_in = LoPW'(num[LoW-1:0]) * LoPW'(scale);
      a_phi_in = HiPW'(num[MagW-1:LoW]) * HiPW'(scale);
   end

   assign b_prod_in = (ProdW'(a_phi_ff) << LoW) + ProdW'(a_plo_ff);

   always_comb begin
      hi_ext   = CmpW'(b_prod_ff[ProdW-1:MagW]);
      den_ext  = CmpW'(b_aux_ff);
      ovf      = hi_ext >= den_ext;
      c_ctl_in = b_ctl_ff;
      if (b_ctl_ff.kind == KIND_DIV && ovf) begin
         c_ctl_in.kind = KIND_OVF;
      end
      c_rem_in  = hi_ext[MagW-1:0];
      c_work_in = b_prod_ff[MagW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
         c_ctl_ff <= '0;
      end else if (enable) begin
         a_ctl_ff <= a_ctl_in;
         b_ctl_ff <= a_ctl_ff;
         c_ctl_ff <= c_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_aux_ff  <= a_aux_in;
         a_plo_ff  <= a_plo_in;
         a_phi_ff  <= a_phi_in;
         b_aux_ff  <= a_aux_ff;
         b_prod_ff <= b_prod_in;
         c_aux_ff  <= b_aux_ff;
         c_rem_ff  <= c_rem_in;
         c_work_ff <= c_work_in;
      end
   end

   assign dn_ctl  = c_ctl_ff;
   assign dn_rem  = c_rem_ff;
   assign dn_work = c_work_ff;
   assign dn_aux  = c_aux_ff;

endmodule

`default_nettype wire

FILE: src/sfpr_cell.sv
// One restoring division cell: produces one quotient bit per request.
`default_nettype none

module sfpr_cell
   import sfpr_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_W_DEF,
   localparam int MagW = DATA_WIDTH - 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  enable,
   input  wire sfpr_ctl_type          up_ctl,
   input  wire logic [MagW-1:0]       up_rem,
   input  wire logic [MagW-1:0]       up_work,
   input  wire logic [DATA_WIDTH-1:0] up_aux,
   output sfpr_ctl_type               dn_ctl,
   output logic [MagW-1:0]            dn_rem,
   output logic [MagW-1:0]            dn_work,
   output logic [DATA_WIDTH-1:0]      dn_aux
);

   sfpr_ctl_type          ctl_ff;
   logic [MagW-1:0]       rem_ff, rem_in;
   logic [MagW-1:0]       work_ff, work_in;
   logic [DATA_WIDTH-1:0] aux_ff;

   logic [DATA_WIDTH-1:0] trial;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;

   always_comb begin
      trial = {up_rem, up_work[MagW-1]};
      diff  = {1'b0, trial} - {1'b0, up_aux};
      fits  = ~diff[DATA_WIDTH];
      if (up_ctl.kind == KIND_DIV) begin
         rem_in  = fits ? diff[MagW-1:0] : trial[MagW-1:0];
         work_in = {up_work[MagW-2:0], fits};
      end else begin
         rem_in  = up_rem;
         work_in = up_work;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
         aux_ff  <= up_aux;
      end
   end

   assign dn_ctl  = ctl_ff;
   assign dn_rem  = rem_ff;
   assign dn_work = work_ff;
   assign dn_aux  = aux_ff;

endmodule

`default_nettype wire

FILE: src/scaled_fixed_point_ratio_core.sv
// Top level of the scaled fixed-point ratio core: front stages, cell chain, output register.
//
// A request carries a signed numerator and denominator; the response carries
// floor(numerator * scale / denominator) and a status code.
// A denominator that is zero or negative returns the numerator with status ok.
// A negative numerator with a positive denominator returns zero with the negative status, and a
// result above the largest signed value returns zero with the overflow status.
// The scale is written through the csr port, which is always ready; write it only
// while no request is in flight.
// The pipeline has three front stages (partial products, product sum, overflow check),
// one division cell per magnitude bit, and the output register.
// One request is accepted per cycle while req_stall is low; the cell chain is fully pipelined.
// When the receiver stalls a held response, the whole pipeline holds and req_stall
// rises in the same cycle; bubbles drain whenever the output register is free.
// Reset empties the pipeline and loads the default scale of 100000.
`default_nettype none

module scaled_fixed_point_ratio_core
   import sfpr_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_W_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire sfpr_req_type       req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output sfpr_rsp_type            rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [SCALE_W-1:0] csr_data
);

   localparam int MagW = DATA_WIDTH - 1;

   logic                  enable;
   logic [SCALE_W-1:0]    scale_ff;

   sfpr_ctl_type          chain_ctl  [MagW+1];
   logic [MagW-1:0]       chain_rem  [MagW+1];
   logic [MagW-1:0]       chain_work [MagW+1];
   logic [DATA_WIDTH-1:0] chain_aux  [MagW+1];

   logic                  rsp_valid_ff;
   sfpr_rsp_type          rsp_data_ff, rsp_data_in;

   assign enable    = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~enable;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_valid) begin
         scale_ff <= csr_data;
      end
   end

   sfpr_front #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .scale    (scale_ff),
      .up_valid (req_valid),
      .up_data  (req_data),
      .dn_ctl   (chain_ctl[0]),
      .dn_rem   (chain_rem[0]),
      .dn_work  (chain_work[0]),
      .dn_aux   (chain_aux[0])
   );

   for (genvar i = 0; i < MagW; i++) begin : g_cell
      sfpr_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .up_ctl  (chain_ctl[i]),
         .up_rem  (chain_rem[i]),
         .up_work (chain_work[i]),
         .up_aux  (chain_aux[i]),
         .dn_ctl  (chain_ctl[i+1]),
         .dn_rem  (chain_rem[i+1]),
         .dn_work (chain_work[i+1]),
         .dn_aux  (chain_aux[i+1])
      );
   end

   always_comb begin
      case (chain_ctl[MagW].kind)
         KIND_DIV: begin
            rsp_data_in.ratio  = FIELD_W'(chain_work[MagW]);
            rsp_data_in.status = STATUS_OK;
         end
         KIND_PASS: begin
            rsp_data_in.ratio  = FIELD_W'(signed'(chain_aux[MagW]));
            rsp_data_in.status = STATUS_OK;
         end
         KIND_NEG: begin
            rsp_data_in.ratio  = '0;
            rsp_data_in.status = STATUS_NEG;
         end
         default: begin
            rsp_data_in.ratio  = '0;
            rsp_data_in.status = STATUS_OVF;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= chain_ctl[MagW].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
